>>> src/lpfp_pkg.sv
`default_nettype none
package lpfp_pkg;

    localparam int unsigned HDR_POS_W   = 4;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [HDR_POS_W-1:0] HDR_POS_MAGIC_LAST = 4'd3;
    localparam logic [HDR_POS_W-1:0] HDR_POS_VERSION    = 4'd4;
    localparam logic [HDR_POS_W-1:0] HDR_POS_TYPE       = 4'd5;
    localparam logic [HDR_POS_W-1:0] HDR_POS_LAST       = 4'd9;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VERSION = 2'd1;

    localparam logic [31:0] MAGIC_RESET   = 32'd0;
    localparam logic [7:0]  VERSION_RESET = 8'd1;

    localparam logic [1:0] STATUS_PAYLOAD     = 2'd0;
    localparam logic [1:0] STATUS_EMPTY_FRAME = 2'd1;
    localparam logic [1:0] STATUS_BAD_MAGIC   = 2'd2;
    localparam logic [1:0] STATUS_BAD_VERSION = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  frame_type;
        logic [31:0] frame_length;
        logic [7:0]  payload_byte;
        logic        frame_end;
    } t_result;

endpackage
`default_nettype wire

>>> src/lpfp_in_if.sv
`default_nettype none
interface lpfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

>>> src/lpfp_out_if.sv
`default_nettype none
interface lpfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [31:0] frame_length;
    logic [7:0]  payload_byte;
    logic        frame_end;

    modport source (output valid, output status, output frame_type, output frame_length,
                    output payload_byte, output frame_end, input ready);
    modport sink   (input valid, input status, input frame_type, input frame_length,
                    input payload_byte, input frame_end, output ready);
endinterface
`default_nettype wire

>>> src/lpfp_parse.sv
`default_nettype none
module lpfp_parse (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lpfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lpfp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_fire,
    input  wire logic [7:0]                      i_rx_byte,
    output      logic                            o_res_valid,
    output      lpfp_pkg::t_result               o_res
);

    logic [31:0] r_exp_magic;
    logic [7:0]  r_exp_version;

    logic [lpfp_pkg::HDR_POS_W-1:0] r_hdr_pos, n_hdr_pos;
    logic [31:0] r_magic, n_magic;
    logic [7:0]  r_version, n_version;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_length, n_length;
    logic [31:0] r_remaining, n_remaining;
    logic        r_in_payload, n_in_payload;

    logic [lpfp_pkg::HDR_POS_W-1:0] pos;
    logic                           last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= lpfp_pkg::MAGIC_RESET;
            r_exp_version <= lpfp_pkg::VERSION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lpfp_pkg::CFG_IDX_MAGIC:   r_exp_magic   <= i_cfg_wdata;
                lpfp_pkg::CFG_IDX_VERSION: r_exp_version <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_hdr_pos    = r_hdr_pos;
        n_magic      = r_magic;
        n_version    = r_version;
        n_type       = r_type;
        n_length     = r_length;
        n_remaining  = r_remaining;
        n_in_payload = r_in_payload;
        o_res_valid  = 1'b0;
        o_res        = '0;

        pos  = (r_hdr_pos > lpfp_pkg::HDR_POS_LAST) ? lpfp_pkg::HDR_POS_LAST : r_hdr_pos;
        last = (r_remaining <= 32'd1);

        if (r_in_payload) begin
            o_res_valid         = 1'b1;
            o_res.status        = lpfp_pkg::STATUS_PAYLOAD;
            o_res.frame_type    = r_type;
            o_res.frame_length  = r_length;
            o_res.payload_byte  = i_rx_byte;
            o_res.frame_end     = last;
            if (last) begin
                n_remaining  = '0;
                n_in_payload = 1'b0;
                n_hdr_pos    = '0;
            end else begin
                n_remaining = r_remaining - 32'd1;
            end
        end else begin
            if (pos <= lpfp_pkg::HDR_POS_MAGIC_LAST) begin
                n_magic = {r_magic[23:0], i_rx_byte};
            end else if (pos == lpfp_pkg::HDR_POS_VERSION) begin
                n_version = i_rx_byte;
            end else if (pos == lpfp_pkg::HDR_POS_TYPE) begin
                n_type = i_rx_byte;
            end else begin
                n_length = {r_length[23:0], i_rx_byte};
            end

            if (pos != lpfp_pkg::HDR_POS_LAST) begin
                n_hdr_pos = pos + 4'd1;
            end else begin
                n_hdr_pos          = '0;
                o_res.frame_type   = n_type;
                o_res.frame_length = n_length;
                o_res.frame_end    = 1'b1;
                if (n_magic != r_exp_magic) begin
                    o_res_valid  = 1'b1;
                    o_res.status = lpfp_pkg::STATUS_BAD_MAGIC;
                end else if (n_version != r_exp_version) begin
                    o_res_valid  = 1'b1;
                    o_res.status = lpfp_pkg::STATUS_BAD_VERSION;
                end else if (n_length == 32'd0) begin
                    o_res_valid  = 1'b1;
                    o_res.status = lpfp_pkg::STATUS_EMPTY_FRAME;
                end else begin
                    n_remaining  = n_length;
                    n_in_payload = 1'b1;
                end
            end
        end

        o_res_valid = o_res_valid & i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos    <= '0;
            r_magic      <= '0;
            r_version    <= '0;
            r_type       <= '0;
            r_length     <= '0;
            r_remaining  <= '0;
            r_in_payload <= 1'b0;
        end else if (i_fire) begin
            r_hdr_pos    <= n_hdr_pos;
            r_magic      <= n_magic;
            r_version    <= n_version;
            r_type       <= n_type;
            r_length     <= n_length;
            r_remaining  <= n_remaining;
            r_in_payload <= n_in_payload;
        end
    end

endmodule
`default_nettype wire

>>> src/lpfp_out_buf.sv
`default_nettype none
module lpfp_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  lpfp_pkg::t_result      i_data,
    output      logic              o_has_room,
    output      logic              o_valid,
    input  wire logic              i_ready,
    output      lpfp_pkg::t_result o_data
);

    lpfp_pkg::t_result r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_has_room = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign o_data     = r_mem[r_rd_ptr];
    assign pop        = o_valid & i_ready;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> src/length_prefixed_frame_parser_core.sv
// Length-prefixed frame parser.
// Input channel i_rx carries one stream byte per beat. Each frame is a 10-byte
// header (big-endian magic, version, type, big-endian payload length) and then
// the payload. Output channel o_res carries one result beat per payload byte,
// or a single beat for an empty frame, a bad magic or a bad version.
// Header bytes produce no beat until the tenth one is checked.
// The expected magic and version are written through the i_cfg port; index 0
// is the magic and index 1 the version. The user must write them only while
// the block is idle; the block itself does not enforce this. One byte is
// accepted every cycle while i_rx.ready is high. Each result is pushed into
// a two-entry output buffer when its byte is accepted; o_res reads the buffer.
// When the receiver stalls, the buffer holds up to two results and i_rx.ready
// drops only when both entries are full.
// Synchronous active-low reset clears the parser to the start of a header,
// empties the buffer and restores the expected magic to 0 and version to 1.
`default_nettype none
module length_prefixed_frame_parser_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lpfp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lpfp_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    lpfp_in_if.sink                              i_rx,
    lpfp_out_if.source                           o_res
);

    logic              fire;
    logic              room;
    logic              res_valid;
    lpfp_pkg::t_result res;
    lpfp_pkg::t_result out_data;

    assign i_rx.ready = room;
    assign fire       = i_rx.valid & room;

    lpfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_rx_byte   (i_rx.rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lpfp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (res_valid),
        .i_data     (res),
        .o_has_room (room),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_data     (out_data)
    );

    assign o_res.status       = out_data.status;
    assign o_res.frame_type   = out_data.frame_type;
    assign o_res.frame_length = out_data.frame_length;
    assign o_res.payload_byte = out_data.payload_byte;
    assign o_res.frame_end    = out_data.frame_end;

endmodule
`default_nettype wire

>>> test/tb_frame_checker.sv
module tb_frame_checker
    import lpfp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    lpfp_in_if                         i_rx,
    lpfp_out_if                        i_res,
    output int                         o_pending,
    output int                         o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]          magic_cfg;
    logic [7:0]           version_cfg;
    logic [HDR_POS_W-1:0] hdr_pos;
    logic [31:0]          magic_acc;
    logic [7:0]           version_acc;
    logic [7:0]           type_acc;
    logic [31:0]          length_acc;
    logic [31:0]          payload_left;
    logic                 in_payload;
    t_result              expected_beats[$];

    function automatic t_result make_beat(input logic [1:0] st, input logic [7:0] pb,
                                          input logic last);
        t_result beat;
        beat.status       = st;
        beat.frame_type   = type_acc;
        beat.frame_length = length_acc;
        beat.payload_byte = pb;
        beat.frame_end    = last;
        return beat;
    endfunction

    task automatic queue_beat(input t_result beat);
        expected_beats.insert(expected_beats.size(), beat);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [HDR_POS_W-1:0] pos;
        if (in_payload) begin
            queue_beat(make_beat(STATUS_PAYLOAD, b, payload_left <= 32'd1));
            if (payload_left <= 32'd1) begin
                payload_left = 32'd0;
                in_payload   = 1'b0;
                hdr_pos      = '0;
            end else begin
                payload_left = payload_left - 32'd1;
            end
        end else begin
            pos = (hdr_pos > HDR_POS_LAST) ? HDR_POS_LAST : hdr_pos;
            if (pos <= HDR_POS_MAGIC_LAST) begin
                magic_acc = {magic_acc[23:0], b};
            end else if (pos == HDR_POS_VERSION) begin
                version_acc = b;
            end else if (pos == HDR_POS_TYPE) begin
                type_acc = b;
            end else begin
                length_acc = {length_acc[23:0], b};
            end
            if (pos != HDR_POS_LAST) begin
                hdr_pos = pos + 1'b1;
            end else begin
                hdr_pos = '0;
                if (magic_acc != magic_cfg) begin
                    queue_beat(make_beat(STATUS_BAD_MAGIC, 8'd0, 1'b1));
                end else if (version_acc != version_cfg) begin
                    queue_beat(make_beat(STATUS_BAD_VERSION, 8'd0, 1'b1));
                end else if (length_acc == 32'd0) begin
                    queue_beat(make_beat(STATUS_EMPTY_FRAME, 8'd0, 1'b1));
                end else begin
                    payload_left = length_acc;
                    in_payload   = 1'b1;
                end
            end
        end
    endtask

    task automatic check_beat();
        t_result want;
        if (expected_beats.size() == 0) begin
            $error("result beat with no expectation: status %0d, frame_type %0h",
                   i_res.status, i_res.frame_type);
            o_fail_count++;
        end else begin
            want = expected_beats.pop_front();
            if (i_res.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, i_res.status);
                o_fail_count++;
            end
            if (i_res.frame_type !== want.frame_type) begin
                $error("frame_type: expected %0h, got %0h", want.frame_type, i_res.frame_type);
                o_fail_count++;
            end
            if (i_res.frame_length !== want.frame_length) begin
                $error("frame_length: expected %0h, got %0h", want.frame_length,
                       i_res.frame_length);
                o_fail_count++;
            end
            if (i_res.payload_byte !== want.payload_byte) begin
                $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                       i_res.payload_byte);
                o_fail_count++;
            end
            if (i_res.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, i_res.frame_end);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            magic_cfg    = MAGIC_RESET;
            version_cfg  = VERSION_RESET;
            hdr_pos      = '0;
            magic_acc    = 32'd0;
            version_acc  = 8'd0;
            type_acc     = 8'd0;
            length_acc   = 32'd0;
            payload_left = 32'd0;
            in_payload   = 1'b0;
            expected_beats.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IDX_MAGIC) begin
                    magic_cfg = i_cfg_wdata;
                end else if (i_cfg_idx == CFG_IDX_VERSION) begin
                    version_cfg = i_cfg_wdata[7:0];
                end
            end
            if (i_rx.valid && i_rx.ready) begin
                parse_byte(i_rx.rx_byte);
            end
            if (i_res.valid && i_res.ready) begin
                check_beat();
            end
        end
        o_pending = expected_beats.size();
    end
endmodule

>>> test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lpfp_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int BURST_MAX   = 14;
    localparam int PHASES      = 6;
    localparam int PHASE_BYTES = 180;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    pending;
    int                    fail_count;
    int                    cycle_count;
    int                    bytes_sent;
    int                    hold_requested;
    int                    hold_served;
    bit                    src_idle_on;
    bit                    snk_idle_on;
    logic [31:0]           cur_magic;
    logic [7:0]            cur_version;

    lpfp_in_if  rx_bus();
    lpfp_out_if res_bus();

    length_prefixed_frame_parser_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_rx        (rx_bus),
        .o_res       (res_bus)
    );

    tb_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_rx         (rx_bus),
        .i_res        (res_bus),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL length_prefixed_frame_parser_core");
            $finish;
        end
    end

    // The receiver stalls in short random bursts, and for a long stretch on request.
    initial begin
        int stall_left;
        int hold_left;
        stall_left    = 0;
        hold_left     = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requested != hold_served) begin
                hold_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, BURST_MAX) - 1;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (src_idle_on && $urandom_range(0, 7) == 0) begin
            rx_bus.valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(negedge i_clk);
        end
        rx_bus.valid   <= 1'b1;
        rx_bus.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [31:0] magic, input logic [7:0] version,
                              input logic [7:0] ftype, input logic [31:0] length,
                              input int payload_count);
        for (int i = 0; i < 4; i++) begin
            send_byte(magic[31-8*i -: 8]);
        end
        send_byte(version);
        send_byte(ftype);
        for (int i = 0; i < 4; i++) begin
            send_byte(length[31-8*i -: 8]);
        end
        repeat (payload_count) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        rx_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
    endtask

    initial begin
        int          sel;
        int          phase_target;
        logic [31:0] len;
        logic [31:0] flip;
        logic [7:0]  vflip;
        logic [7:0]  ftype;

        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = 8'd0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_IDX_MAGIC;
        cfg_wdata      = '0;
        i_rst_n        = 1'b0;
        src_idle_on    = 1'b1;
        snk_idle_on    = 1'b1;
        cur_magic      = MAGIC_RESET;
        cur_version    = VERSION_RESET;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset configuration: empty frame, short payloads, bad magic with a
        // wrong version too, and a bad version.
        send_frame(cur_magic, cur_version, 8'h00, 32'd0, 0);
        send_frame(cur_magic, cur_version, 8'hFF, 32'd1, 1);
        send_frame(32'hFFFF_FFFF, 8'hFF, 8'h5A, 32'hFFFF_FFFF, 0);
        send_frame(cur_magic, 8'h00, 8'hA5, 32'h8000_0000, 0);
        send_frame(cur_magic, cur_version, 8'h3C, 32'd3, 3);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1: begin
                        cur_magic   = 32'hFFFF_FFFF;
                        cur_version = 8'hFF;
                    end
                    2: begin
                        cur_magic   = 32'd0;
                        cur_version = 8'd0;
                    end
                    3: begin
                        cur_magic   = $urandom;
                        cur_version = 8'($urandom_range(0, 255));
                    end
                    4: begin
                        cur_magic   = $urandom;
                        cur_version = VERSION_RESET;
                    end
                    default: begin
                        cur_magic   = $urandom;
                        cur_version = 8'($urandom_range(0, 255));
                        src_idle_on = 1'b0;
                        snk_idle_on = 1'b0;
                    end
                endcase
                write_reg(CFG_IDX_MAGIC, cur_magic);
                write_reg(CFG_IDX_VERSION, {24'd0, cur_version});
                if (phase == 3) begin
                    write_reg(CFG_IDX_SPARE_A, $urandom);
                    write_reg(CFG_IDX_SPARE_B, $urandom);
                end
                cfg_we <= 1'b0;
            end

            if (phase == 1) begin
                hold_requested++;
                send_frame(cur_magic, cur_version, 8'h42, 32'd24, 24);
            end

            phase_target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_target) begin
                sel   = $urandom_range(0, 99);
                ftype = 8'($urandom_range(0, 255));
                if (sel < 60) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48)
                                                      : $urandom_range(1, 8);
                    send_frame(cur_magic, cur_version, ftype, len, int'(len));
                end else if (sel < 72) begin
                    send_frame(cur_magic, cur_version, ftype, 32'd0, 0);
                end else if (sel < 86) begin
                    flip = $urandom;
                    if (flip == 32'd0) begin
                        flip = 32'd1;
                    end
                    vflip = ($urandom_range(0, 1) == 0) ? cur_version
                                                        : 8'($urandom_range(0, 255));
                    send_frame(cur_magic ^ flip, vflip, ftype, $urandom, 0);
                end else begin
                    vflip = 8'($urandom_range(1, 255));
                    send_frame(cur_magic, cur_version ^ vflip, ftype, $urandom, 0);
                end
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("PASS length_prefixed_frame_parser_core");
        end else begin
            $display("FAIL length_prefixed_frame_parser_core");
        end
        $finish;
    end
endmodule
